[hw/rtl/lps_pkg.sv]
// lps_pkg: command codes, register indexes and fixed widths for the line stepper.
// No dependencies; imported by the step logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    // command carried in s_tuser
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam int SCREEN_BITS = 12;
    localparam int COLOR_BITS  = 32;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

endpackage

`default_nettype wire

[hw/rtl/line_pixel_stepper.sv]
// line_pixel_stepper: top level of the Bresenham line rasterizer.
// Uses lps_pkg, lps_step and lps_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line stepper. A start request (s_tuser = 0) loads two endpoints and a color
// and yields the first pixel; each advance request (s_tuser = 1) yields the next pixel,
// and an advance with no line in progress yields nothing. The step logic updates the line
// state registers in the cycle a request is accepted, so a request can be taken on every
// clock while the output queue has room. Pixels leave through a two-entry output queue
// that registers them, and s_tready drops only when that queue is full. m_tlast
// marks the final pixel of the line; m_tuser flags pixels inside the screen size set
// through the write port (width and height reset to 640 and 480).
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration writes
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_addr,
    input  wire logic [SCREEN_BITS-1:0] cfg_wdata,
    // requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // x_start, y_start, x_end, y_end, line_color, zero pad
    input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  wire logic                   s_tuser,
    // pixels
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0]      m_tdata,
    // visible
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int IN_BITS   = 4 * COORD_BITS + COLOR_BITS;
    localparam int OUT_BITS  = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    localparam int ERR_BITS  = COORD_BITS + 4;
    localparam int BUF_BITS  = OUT_BITS + 2;

    logic [SCREEN_BITS-1:0]       screen_width_reg;
    logic [SCREEN_BITS-1:0]       screen_height_reg;

    logic signed [COORD_BITS-1:0] cur_x_reg,     cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,     cur_y_next;
    logic signed [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic signed [ERR_BITS-1:0]   err_term_reg,  err_term_next;
    logic [COORD_BITS-1:0]        abs_dx_reg,    abs_dx_next;
    logic [COORD_BITS-1:0]        abs_dy_reg,    abs_dy_next;
    logic                         x_major_reg,   x_major_next;
    logic                         minor_up_reg,  minor_up_next;
    logic                         active_reg,    active_next;
    logic [COLOR_BITS-1:0]        held_color_reg, held_color_next;

    logic signed [COORD_BITS-1:0] in_x_start;
    logic signed [COORD_BITS-1:0] in_y_start;
    logic signed [COORD_BITS-1:0] in_x_end;
    logic signed [COORD_BITS-1:0] in_y_end;
    logic [COLOR_BITS-1:0]        in_color;

    logic                         accept;
    logic                         res_valid;
    logic                         res_visible;
    logic                         res_last;
    logic                         buf_ready;
    logic [BUF_BITS-1:0]          buf_in;
    logic [BUF_BITS-1:0]          buf_out;

    assign in_x_start = s_tdata[COORD_BITS-1:0];
    assign in_y_start = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_x_end   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_y_end   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign in_color   = s_tdata[IN_BITS-1:4*COORD_BITS];

    assign s_tready = buf_ready;
    assign accept   = s_tvalid && s_tready;

    lps_step #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_step (
        .cmd            (s_tuser),
        .x_start        (in_x_start),
        .y_start        (in_y_start),
        .x_end          (in_x_end),
        .y_end          (in_y_end),
        .screen_width   (screen_width_reg),
        .screen_height  (screen_height_reg),
        .cur_x          (cur_x_reg),
        .cur_y          (cur_y_reg),
        .major_end      (major_end_reg),
        .err_term       (err_term_reg),
        .abs_dx         (abs_dx_reg),
        .abs_dy         (abs_dy_reg),
        .x_major        (x_major_reg),
        .minor_up       (minor_up_reg),
        .active         (active_reg),
        .cur_x_next     (cur_x_next),
        .cur_y_next     (cur_y_next),
        .major_end_next (major_end_next),
        .err_term_next  (err_term_next),
        .abs_dx_next    (abs_dx_next),
        .abs_dy_next    (abs_dy_next),
        .x_major_next   (x_major_next),
        .minor_up_next  (minor_up_next),
        .active_next    (active_next),
        .res_valid      (res_valid),
        .res_visible    (res_visible),
        .res_last       (res_last)
    );

    assign held_color_next = (s_tuser == CMD_START) ? in_color : held_color_reg;
    assign buf_in = {res_last, res_visible, held_color_next, cur_y_next, cur_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            active_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                    CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                    default:           screen_width_reg  <= screen_width_reg;
                endcase
            end
            if (accept) begin
                active_reg <= active_next;
            end
        end
    end

    // line state payload, only meaningful while a line is active
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            major_end_reg  <= major_end_next;
            err_term_reg   <= err_term_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            x_major_reg    <= x_major_next;
            minor_up_reg   <= minor_up_next;
            held_color_reg <= held_color_next;
        end
    end

    lps_out_buf #(
        .WIDTH (BUF_BITS)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_ready  (buf_ready),
        .in_data   (buf_in),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_out)
    );

    assign m_tdata = (OUT_BYTES*8)'(buf_out[OUT_BITS-1:0]);
    assign m_tuser = buf_out[OUT_BITS];
    assign m_tlast = buf_out[OUT_BITS+1];

    // a start always yields a pixel
    a_start_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == CMD_START |=> m_tvalid)
        else $error("start request produced no pixel");

    // an advance with no line in progress yields nothing
    a_idle_advance_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == CMD_ADVANCE && !active_reg && !m_tvalid |=> !m_tvalid)
        else $error("pixel produced with no active line");

    // the final pixel ends the line
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_last |=> !active_reg)
        else $error("line still active after its last pixel");

    // an active line has not reached its end on the major axis
    a_major_before_end: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (x_major_reg ? (cur_x_reg < major_end_reg)
                                    : (cur_y_reg < major_end_reg)))
        else $error("active line beyond its end point");

endmodule

`default_nettype wire

[hw/rtl/lps_step.sv]
// lps_step: one Bresenham step (start or advance) as combinational logic.
// Depends on lps_pkg for command codes and screen register width.
`timescale 1ns / 1ps
`default_nettype none

module lps_step
    import lps_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = COORD_BITS + 4
) (
    input  wire logic                         cmd,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    input  wire logic [SCREEN_BITS-1:0]       screen_width,
    input  wire logic [SCREEN_BITS-1:0]       screen_height,
    // current line state
    input  wire logic signed [COORD_BITS-1:0] cur_x,
    input  wire logic signed [COORD_BITS-1:0] cur_y,
    input  wire logic signed [COORD_BITS-1:0] major_end,
    input  wire logic signed [ERR_BITS-1:0]   err_term,
    input  wire logic [COORD_BITS-1:0]        abs_dx,
    input  wire logic [COORD_BITS-1:0]        abs_dy,
    input  wire logic                         x_major,
    input  wire logic                         minor_up,
    input  wire logic                         active,
    // next line state
    output logic signed [COORD_BITS-1:0]      cur_x_next,
    output logic signed [COORD_BITS-1:0]      cur_y_next,
    output logic signed [COORD_BITS-1:0]      major_end_next,
    output logic signed [ERR_BITS-1:0]        err_term_next,
    output logic [COORD_BITS-1:0]             abs_dx_next,
    output logic [COORD_BITS-1:0]             abs_dy_next,
    output logic                              x_major_next,
    output logic                              minor_up_next,
    output logic                              active_next,
    // pixel produced by this request
    output logic                              res_valid,
    output logic                              res_visible,
    output logic                              res_last
);

    localparam int CMP_BITS = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    logic signed [COORD_BITS:0]     dx;
    logic signed [COORD_BITS:0]     dy;
    logic signed [COORD_BITS:0]     neg_dx;
    logic signed [COORD_BITS:0]     neg_dy;
    logic [COORD_BITS-1:0]          adx;
    logic [COORD_BITS-1:0]          ady;
    logic signed [ERR_BITS-1:0]     e_adx;
    logic signed [ERR_BITS-1:0]     e_ady;
    logic signed [ERR_BITS-1:0]     s_adx;
    logic signed [ERR_BITS-1:0]     s_ady;
    logic [COORD_BITS-1:0]          minor_delta;
    logic signed [COORD_BITS-1:0]   major_pos;
    logic                           fin;
    logic                           x_vis;
    logic                           y_vis;

    always_comb begin
        dx     = (COORD_BITS+1)'(x_end) - (COORD_BITS+1)'(x_start);
        dy     = (COORD_BITS+1)'(y_end) - (COORD_BITS+1)'(y_start);
        neg_dx = -dx;
        neg_dy = -dy;
        adx    = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady    = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        e_adx  = $signed(ERR_BITS'(adx));
        e_ady  = $signed(ERR_BITS'(ady));
        s_adx  = $signed(ERR_BITS'(abs_dx));
        s_ady  = $signed(ERR_BITS'(abs_dy));
        minor_delta = minor_up ? COORD_BITS'(1) : '1;

        cur_x_next     = cur_x;
        cur_y_next     = cur_y;
        major_end_next = major_end;
        err_term_next  = err_term;
        abs_dx_next    = abs_dx;
        abs_dy_next    = abs_dy;
        x_major_next   = x_major;
        minor_up_next  = minor_up;
        res_valid      = 1'b0;

        case (cmd)
            CMD_START: begin
                res_valid     = 1'b1;
                abs_dx_next   = adx;
                abs_dy_next   = ady;
                minor_up_next = (dx[COORD_BITS] && dy[COORD_BITS]) ||
                                (dx > 0 && dy > 0);
                x_major_next  = ady <= adx;
                if (ady <= adx) begin
                    err_term_next = (e_ady <<< 1) - e_adx;
                    if (!dx[COORD_BITS]) begin
                        cur_x_next     = x_start;
                        cur_y_next     = y_start;
                        major_end_next = x_end;
                    end else begin
                        cur_x_next     = x_end;
                        cur_y_next     = y_end;
                        major_end_next = x_start;
                    end
                end else begin
                    err_term_next = (e_adx <<< 1) - e_ady;
                    if (!dy[COORD_BITS]) begin
                        cur_x_next     = x_start;
                        cur_y_next     = y_start;
                        major_end_next = y_end;
                    end else begin
                        cur_x_next     = x_end;
                        cur_y_next     = y_end;
                        major_end_next = y_start;
                    end
                end
            end
            CMD_ADVANCE: begin
                res_valid = active;
                if (active) begin
                    if (x_major) begin
                        cur_x_next = cur_x + COORD_BITS'(1);
                        if (err_term < 0) begin
                            err_term_next = err_term + (s_ady <<< 1);
                        end else begin
                            cur_y_next    = cur_y + minor_delta;
                            err_term_next = err_term + ((s_ady - s_adx) <<< 1);
                        end
                    end else begin
                        cur_y_next = cur_y + COORD_BITS'(1);
                        if (err_term <= 0) begin
                            err_term_next = err_term + (s_adx <<< 1);
                        end else begin
                            cur_x_next    = cur_x + minor_delta;
                            err_term_next = err_term + ((s_adx - s_ady) <<< 1);
                        end
                    end
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        // emitted pixel comes from the updated position
        major_pos = x_major_next ? cur_x_next : cur_y_next;
        fin       = major_pos >= major_end_next;
        x_vis     = !cur_x_next[COORD_BITS-1] &&
                    (CMP_BITS'($unsigned(cur_x_next)) < CMP_BITS'(screen_width));
        y_vis     = !cur_y_next[COORD_BITS-1] &&
                    (CMP_BITS'($unsigned(cur_y_next)) < CMP_BITS'(screen_height));
        res_visible = x_vis && y_vis;
        res_last    = fin;
        active_next = res_valid ? !fin : active;
    end

endmodule

`default_nettype wire

[hw/rtl/lps_out_buf.sv]
// lps_out_buf: two-entry output queue that decouples the pixel stream from the step logic.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lps_out_buf #(
    parameter int WIDTH = 58
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking bench for line_pixel_stepper; drives line requests, predicts pixels with
// its own Bresenham stepper or directed rows, compares the stream. Needs lps_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import lps_pkg::*;

    localparam int CW = 12;
    localparam int IN_W = 80;
    localparam int OUT_W = 56;
    localparam int RUN_LIMIT = 300000;
    localparam int RANDOM_REQS = 750;
    localparam int PHASES = 6;
    localparam int HOLDOFF_CYCLES = 4;

    typedef struct packed {
        logic [CW-1:0]         x;
        logic [CW-1:0]         y;
        logic [COLOR_BITS-1:0] rgb;
        logic                  vis;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        logic                  cmd;
        logic [CW-1:0]         xs;
        logic [CW-1:0]         ys;
        logic [CW-1:0]         xe;
        logic [CW-1:0]         ye;
        logic [COLOR_BITS-1:0] rgb;
        logic                  typed;    // expected pixel given in the row itself
        logic                  has_pix;
        pixel_t                pix;
    } line_req_t;

    localparam logic [CW-1:0] C_MIN = 12'h800;
    localparam logic [CW-1:0] C_MAX = 12'h7FF;
    localparam logic [CW-1:0] C_NEG1 = 12'hFFF;
    localparam pixel_t NO_PIX = '0;

    localparam line_req_t DIRECTED [25] = '{
        // advance right after reset, junk on the data lines
        '{CMD_ADVANCE, C_NEG1, C_NEG1, C_NEG1, C_NEG1, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIX},
        // single point at the origin
        '{CMD_START, 12'd0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
        // full-range diagonal, dropped after two steps
        '{CMD_START, C_MIN, C_MIN, C_MAX, C_MAX, 32'h0, 1'b1, 1'b1,
          '{C_MIN, C_MIN, 32'h0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_START, C_MAX, C_MAX, C_MAX, C_MAX, 32'hA5A5_A5A5, 1'b1, 1'b1,
          '{C_MAX, C_MAX, 32'hA5A5_A5A5, 1'b0, 1'b1}},
        // screen corners and the clip edges
        '{CMD_START, 12'd639, 12'd479, 12'd639, 12'd479, 32'h1234_5678, 1'b1, 1'b1,
          '{12'd639, 12'd479, 32'h1234_5678, 1'b1, 1'b1}},
        '{CMD_START, 12'd640, 12'd0, 12'd640, 12'd0, 32'h1234_5678, 1'b1, 1'b1,
          '{12'd640, 12'd0, 32'h1234_5678, 1'b0, 1'b1}},
        '{CMD_START, 12'd0, 12'd480, 12'd0, 12'd480, 32'h1234_5678, 1'b1, 1'b1,
          '{12'd0, 12'd480, 32'h1234_5678, 1'b0, 1'b1}},
        '{CMD_START, C_NEG1, 12'd5, C_NEG1, 12'd5, 32'h1234_5678, 1'b1, 1'b1,
          '{C_NEG1, 12'd5, 32'h1234_5678, 1'b0, 1'b1}},
        // x major, drawn backwards from the second endpoint
        '{CMD_START, 12'd5, 12'd10, 12'd0, 12'd8, 32'h0F0F_0F0F, 1'b1, 1'b1,
          '{12'd0, 12'd8, 32'h0F0F_0F0F, 1'b1, 1'b0}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        // x major with the error term at zero: minor axis steps
        '{CMD_START, 12'd0, 12'd0, 12'd2, 12'd1, 32'h00C0_FFEE, 1'b1, 1'b1,
          '{12'd0, 12'd0, 32'h00C0_FFEE, 1'b1, 1'b0}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        // y major with the error term at zero: minor axis holds, minor steps down
        '{CMD_START, 12'd3, 12'd0, 12'd2, 12'd2, 32'h8000_0001, 1'b1, 1'b1,
          '{12'd3, 12'd0, 32'h8000_0001, 1'b1, 1'b0}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
        // y major drawn from the second endpoint, x falling
        '{CMD_START, 12'd10, 12'd20, 12'd13, 12'd16, 32'h5A5A_5A5A, 1'b1, 1'b1,
          '{12'd13, 12'd16, 32'h5A5A_5A5A, 1'b1, 1'b0}},
        '{CMD_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX}
    };

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_addr = CFG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0] cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   s_tuser = CMD_START;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // stepper state mirrored by the bench
    logic [CW-1:0]          pos_x = '0;
    logic [CW-1:0]          pos_y = '0;
    logic [CW-1:0]          major_stop = '0;
    logic [CW-1:0]          run_x = '0;
    logic [CW-1:0]          run_y = '0;
    logic signed [15:0]     decision = '0;
    bit                     along_x;
    bit                     minor_inc;
    bit                     drawing;
    logic [COLOR_BITS-1:0]  line_rgb = '0;
    logic [SCREEN_BITS-1:0] scr_w = SCREEN_WIDTH_RESET;
    logic [SCREEN_BITS-1:0] scr_h = SCREEN_HEIGHT_RESET;

    pixel_t pixel_q [$];
    bit     gaps_on = 1'b1;
    int     n_fail = 0;
    int     n_req = 0;
    int     n_lines = 0;
    int     n_seen = 0;

    line_pixel_stepper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // advances the mirrored stepper by one request; returns 1 when a pixel comes out
    function automatic bit line_step(input line_req_t r, output pixel_t p);
        int x1, y1, x2, y2, dx, dy, adx, ady, e;
        p = '0;
        if (r.cmd == CMD_START) begin
            x1 = int'($signed(r.xs));
            y1 = int'($signed(r.ys));
            x2 = int'($signed(r.xe));
            y2 = int'($signed(r.ye));
            dx = x2 - x1;
            dy = y2 - y1;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            run_x = CW'(adx);
            run_y = CW'(ady);
            minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            line_rgb = r.rgb;
            along_x = ady <= adx;
            if (along_x) begin
                e = 2 * ady - adx;
                if (dx >= 0) begin
                    pos_x = r.xs; pos_y = r.ys; major_stop = r.xe;
                end else begin
                    pos_x = r.xe; pos_y = r.ye; major_stop = r.xs;
                end
            end else begin
                e = 2 * adx - ady;
                if (dy >= 0) begin
                    pos_x = r.xs; pos_y = r.ys; major_stop = r.ye;
                end else begin
                    pos_x = r.xe; pos_y = r.ye; major_stop = r.ys;
                end
            end
            decision = 16'(e);
            drawing = 1'b1;
        end else begin
            if (!drawing) return 1'b0;
            adx = int'(run_x);
            ady = int'(run_y);
            e = int'(decision);
            if (along_x) begin
                pos_x = pos_x + 1'b1;
                if (e < 0) begin
                    e += 2 * ady;
                end else begin
                    pos_y = minor_inc ? pos_y + 1'b1 : pos_y - 1'b1;
                    e += 2 * (ady - adx);
                end
            end else begin
                pos_y = pos_y + 1'b1;
                // y major keeps the minor axis on a zero error term
                if (e <= 0) begin
                    e += 2 * adx;
                end else begin
                    pos_x = minor_inc ? pos_x + 1'b1 : pos_x - 1'b1;
                    e += 2 * (adx - ady);
                end
            end
            decision = 16'(e);
        end
        p.x = pos_x;
        p.y = pos_y;
        p.rgb = line_rgb;
        p.vis = !pos_x[CW-1] && !pos_y[CW-1] && pos_x < scr_w && pos_y < scr_h;
        p.last = $signed(along_x ? pos_x : pos_y) >= $signed(major_stop);
        if (p.last) drawing = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [CW-1:0] to_coord(input int v);
        if (v > 2047) return C_MAX;
        if (v < -2048) return C_MIN;
        return CW'(v);
    endfunction

    task automatic issue(input line_req_t r, output bit got);
        pixel_t p;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= {r.rgb, r.ye, r.xe, r.ys, r.xs};
        do @(posedge aclk); while (!s_tready);
        got = line_step(r, p);
        if (r.typed) begin
            got = r.has_pix;
            p = r.pix;
        end
        if (got) pixel_q.push_back(p);
        n_req++;
    endtask

    // hold requests until every pixel is out, then let the stepper idle for the holdoff
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
    endtask

    task automatic set_screen(input logic [SCREEN_BITS-1:0] w, input logic [SCREEN_BITS-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    // pixel sink with random backpressure
    initial begin
        int     hold;
        pixel_t want;
        pixel_t seen;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[11:0], m_tdata[23:12], m_tdata[55:24], m_tuser, m_tlast};
                n_seen++;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%h vis=%b last=%b",
                             $time, $signed(seen.x), $signed(seen.y), seen.rgb, seen.vis,
                             seen.last);
                    n_fail++;
                end else begin
                    want = pixel_q.pop_front();
                    if (seen !== want) begin
                        $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h vis=%b last=%b",
                                 $time, $signed(want.x), $signed(want.y), want.rgb, want.vis,
                                 want.last);
                        $display("%0t:                  actual x=%0d y=%0d color=%h vis=%b last=%b",
                                 $time, $signed(seen.x), $signed(seen.y), seen.rgb, seen.vis,
                                 seen.last);
                        n_fail++;
                    end
                end
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 13);
            end
        end
    end

    initial begin
        for (int c = 0; c < RUN_LIMIT; c++) @(posedge aclk);
        $display("%0t: cycle limit reached with %0d pixels outstanding", $time, pixel_q.size());
        $display("line_pixel_stepper regression: fail");
        $finish;
    end

    initial begin
        line_req_t r;
        bit        got;
        int        placed, quota, span, n_adv, ws, hs, reach, x1, y1, dx, dy;
        quota = RANDOM_REQS / PHASES;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) issue(DIRECTED[i], got);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: set_screen(12'd1, 12'd1);
                1: set_screen(12'd0, 12'd0);    // a size of 2048 wraps to zero in 12 bits
                2: set_screen(12'd16, 12'd12);
                3: set_screen(12'd2047, 12'd2047);
                4: set_screen(12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)));
                default: set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
            endcase
            gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            placed = 0;
            while (placed < quota) begin
                ws = (scr_w == 0) ? 2048 : int'(scr_w);
                hs = (scr_h == 0) ? 2048 : int'(scr_h);
                r = '0;
                r.cmd = CMD_START;
                r.rgb = $urandom;
                // mostly near the screen so lines cross the clip edges
                if ($urandom_range(0, 3) == 0) begin
                    x1 = int'($signed(12'($urandom)));
                    y1 = int'($signed(12'($urandom)));
                end else begin
                    x1 = int'($urandom_range(0, ws + 7)) - 4;
                    y1 = int'($urandom_range(0, hs + 7)) - 4;
                end
                r.xs = to_coord(x1);
                r.ys = to_coord(y1);
                reach = $urandom_range(0, 20);
                r.xe = to_coord(x1 + int'($urandom_range(0, 2 * reach)) - reach);
                r.ye = to_coord(y1 + int'($urandom_range(0, 2 * reach)) - reach);
                if ($urandom_range(0, 11) == 0) r.xe = 12'($urandom);
                dx = int'($signed(r.xe)) - int'($signed(r.xs));
                dy = int'($signed(r.ye)) - int'($signed(r.ys));
                dx = dx < 0 ? -dx : dx;
                dy = dy < 0 ? -dy : dy;
                span = dx > dy ? dx : dy;
                // long lines and some short ones get cut short by the next start
                if (span > 40 || $urandom_range(0, 6) == 0)
                    n_adv = $urandom_range(0, span < 30 ? span : 30);
                else
                    n_adv = span + $urandom_range(0, 2);
                issue(r, got);
                placed += int'(got);
                n_lines++;
                for (int k = 0; k < n_adv; k++) begin
                    r.cmd = CMD_ADVANCE;
                    r.xs = 12'($urandom);
                    r.ys = 12'($urandom);
                    r.xe = 12'($urandom);
                    r.ye = 12'($urandom);
                    r.rgb = $urandom;
                    issue(r, got);
                    placed += int'(got);
                end
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        $display("%0d requests over %0d random lines, %0d pixels compared", n_req, n_lines, n_seen);
        $display("screen sizes: reset, 1x1, zero, 16x12, 2047x2047, random, with and without stalls");
        if (n_fail == 0) begin
            $display("line_pixel_stepper regression: pass");
        end else begin
            $display("line_pixel_stepper regression: fail");
        end
        $finish;
    end

endmodule
